[hdl/kcd_pkg.sv]
`timescale 1ns / 1ps
package kcd_pkg;
   localparam int MAX_VERTICES    = 1024;
   localparam int MAX_ADJ_ENTRIES = 8192;
   localparam int MAX_DEGREE      = 1023;
   localparam logic [10:0] VERTEX_COUNT_RESET = 11'd15;

   localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
   localparam logic [1:0] REQ_RUN      = 2'd1;
   localparam logic [1:0] REQ_QUERY    = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_RANGE  = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_PHASE  = 2'd3;
endpackage

[hdl/kcd_req_if.sv]
`timescale 1ns / 1ps
interface kcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [9:0] edge_end_a;
   logic [9:0] edge_end_b;
   logic [9:0] query_vertex;
   modport source (output valid, req_type, edge_end_a, edge_end_b, query_vertex, input ready);
   modport sink (input valid, req_type, edge_end_a, edge_end_b, query_vertex, output ready);
   modport monitor (input valid, ready, req_type, edge_end_a, edge_end_b, query_vertex);
endinterface

[hdl/kcd_rsp_if.sv]
`timescale 1ns / 1ps
interface kcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] core_number;
   modport source (output valid, status, core_number, input ready);
   modport sink (input valid, status, core_number, output ready);
   modport monitor (input valid, ready, status, core_number);
endinterface

[hdl/kcd_ram.sv]
`timescale 1ns / 1ps
module kcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/k_core_decomposition.sv]
`timescale 1ns / 1ps
// The block takes request beats on req_bus and answers each with exactly one
// beat on rsp_bus, unless a csr write of the vertex count cuts it short. An add
// edge reads, then writes the degree and list head memories, or skips the
// writes when refused as full; a query reads the degree; a wrong-phase or
// out-of-range request goes straight to S_PUT, which registers the response,
// and the block is ready again in the same cycle as the response is valid. A
// run beat performs the bucket peeling: it orders the vertices by degree, then
// walks each one's adjacency list and moves down every neighbour of higher
// degree; each step makes at most one read and one write per memory. A clear
// beat sweeps all MAX_VERTICES entries of the degree and list head memories,
// one vertex per cycle. The same sweep runs after reset and after each csr
// write of the vertex count, and no request is taken until it ends. One request
// is in flight at a time; req_bus ready is high only while the block is idle. A
// finished response sits in an output register, so a stalled receiver holds it
// while the block takes the next request, whose answer waits for the register.
module k_core_decomposition #(
   parameter int MAX_VERTICES    = kcd_pkg::MAX_VERTICES,
   parameter int MAX_ADJ_ENTRIES = kcd_pkg::MAX_ADJ_ENTRIES,
   parameter int MAX_DEGREE      = kcd_pkg::MAX_DEGREE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   kcd_req_if.sink     req_bus,
   kcd_rsp_if.source   rsp_bus
);
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = $clog2(MAX_ADJ_ENTRIES);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int PW = AW + 1;
   localparam int BW = VW + 1;
   localparam int NW = (BW > 11) ? BW : 11;
   localparam logic [PW-1:0] EMPTY = PW'(MAX_ADJ_ENTRIES);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_PUT, S_A0, S_A1, S_A2, S_A3, S_Q0, S_Q1,
      S_T0, S_T1, S_Z, S_H0, S_H1, S_H2, S_P0, S_P1, S_L0, S_L1, S_L2,
      S_F0, S_F1, S_M0, S_M1, S_M2, S_E0, S_E1, S_E2, S_E3, S_E4, S_E5
   } state_type;

   state_type     st_ff;
   logic [10:0]   vcount_ff;
   logic [BW-1:0] idx_ff;
   logic [DW-1:0] d_ff, top_ff, dcur_ff, du_ff, da_ff, db_ff;
   logic [BW-1:0] sum_ff, pw_ff;
   logic [VW-1:0] a_ff, b_ff, q_ff, cur_ff, u_ff, pu_ff, w_ff;
   logic [PW-1:0] e_ff, ne_ff, ha_ff, hb_ff, cnt_ff;
   logic          decomp_ff, clr_resp_ff, rsp_valid_ff;
   logic [1:0]    pst_ff, rsp_status_ff;
   logic [9:0]    pcore_ff, rsp_core_ff;

   logic          deg_we, head_we, tgt_we, nxt_we, bst_we, ord_we, pos_we;
   logic [VW-1:0] deg_wa, deg_ra, head_wa, head_ra, ord_wa, ord_ra, pos_wa, pos_ra;
   logic [AW-1:0] tgt_wa, tgt_ra, nxt_wa, nxt_ra;
   logic [DW-1:0] bst_wa, bst_ra, deg_wd, deg_rd;
   logic [PW-1:0] head_wd, head_rd, nxt_wd, nxt_rd;
   logic [VW-1:0] tgt_wd, tgt_rd, ord_wd, ord_rd, pos_wd, pos_rd;
   logic [BW-1:0] bst_wd, bst_rd;

   logic [NW-1:0] live;
   logic [NW-1:0] a_ext, b_ext, q_ext;
   logic          add_fail;
   logic [PW:0]   cnt_plus2;
   logic [DW+1:0] da_inc, db_inc;

   assign live  = (NW'(vcount_ff) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_ff);
   assign a_ext = NW'(req_bus.edge_end_a);
   assign b_ext = NW'(req_bus.edge_end_b);
   assign q_ext = NW'(req_bus.query_vertex);
   assign cnt_plus2 = (PW+1)'(cnt_ff) + (PW+1)'(2);
   assign da_inc = (DW+2)'(da_ff) + ((a_ff == b_ff) ? (DW+2)'(2) : (DW+2)'(1));
   assign db_inc = (DW+2)'(deg_rd) + (DW+2)'(1);
   assign add_fail = (cnt_plus2 > (PW+1)'(MAX_ADJ_ENTRIES)) ||
                     (da_inc > (DW+2)'(MAX_DEGREE)) ||
                     ((a_ff != b_ff) && (db_inc > (DW+2)'(MAX_DEGREE)));

   kcd_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg (
      .clock, .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
   kcd_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
      .clock, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
      .rdata(head_rd));
   kcd_ram #(.WIDTH(VW), .DEPTH(MAX_ADJ_ENTRIES)) u_tgt (
      .clock, .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd));
   kcd_ram #(.WIDTH(PW), .DEPTH(MAX_ADJ_ENTRIES)) u_nxt (
      .clock, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
   kcd_ram #(.WIDTH(BW), .DEPTH(MAX_DEGREE + 1)) u_bst (
      .clock, .we(bst_we), .waddr(bst_wa), .wdata(bst_wd), .raddr(bst_ra), .rdata(bst_rd));
   kcd_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ord (
      .clock, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
   kcd_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pos (
      .clock, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd));

   always_comb begin
      deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_ra = '0;
      head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
      tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = '0;
      nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
      bst_we = 1'b0; bst_wa = '0; bst_wd = '0; bst_ra = '0;
      ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
      pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = '0;
      unique case (st_ff)
         S_CLR: begin
            deg_we = 1'b1; deg_wa = idx_ff[VW-1:0]; deg_wd = '0;
            head_we = 1'b1; head_wa = idx_ff[VW-1:0]; head_wd = EMPTY;
         end
         S_A0: begin
            deg_ra = a_ff; head_ra = a_ff;
         end
         S_A1: begin
            deg_ra = b_ff; head_ra = b_ff;
         end
         S_A2: begin
            if (!add_fail) begin
               tgt_we = 1'b1; tgt_wa = cnt_ff[AW-1:0]; tgt_wd = b_ff;
               nxt_we = 1'b1; nxt_wa = cnt_ff[AW-1:0]; nxt_wd = ha_ff;
               head_we = 1'b1; head_wa = a_ff; head_wd = cnt_ff;
               deg_we = 1'b1; deg_wa = a_ff; deg_wd = DW'(da_inc);
            end
         end
         S_A3: begin
            tgt_we = 1'b1; tgt_wa = AW'(cnt_ff + PW'(1)); tgt_wd = a_ff;
            nxt_we = 1'b1; nxt_wa = AW'(cnt_ff + PW'(1)); nxt_wd = hb_ff;
            head_we = 1'b1; head_wa = b_ff; head_wd = cnt_ff + PW'(1);
            if (a_ff != b_ff) begin
               deg_we = 1'b1; deg_wa = b_ff; deg_wd = DW'(db_ff + DW'(1));
            end
         end
         S_Q0: deg_ra = q_ff;
         S_T0, S_H0, S_L0: deg_ra = idx_ff[VW-1:0];
         S_Z: begin
            bst_we = 1'b1; bst_wa = d_ff; bst_wd = '0;
         end
         S_H1, S_L1: bst_ra = deg_rd;
         S_H2: begin
            bst_we = 1'b1; bst_wa = du_ff; bst_wd = bst_rd + BW'(1);
         end
         S_P0: bst_ra = d_ff;
         S_P1: begin
            bst_we = 1'b1; bst_wa = d_ff; bst_wd = sum_ff;
         end
         S_L2: begin
            bst_we = 1'b1; bst_wa = du_ff; bst_wd = bst_rd + BW'(1);
            pos_we = 1'b1; pos_wa = idx_ff[VW-1:0]; pos_wd = bst_rd[VW-1:0];
            ord_we = 1'b1; ord_wa = bst_rd[VW-1:0]; ord_wd = idx_ff[VW-1:0];
         end
         S_F0: begin
            if (d_ff == '0) begin
               bst_we = 1'b1; bst_wa = '0; bst_wd = '0;
            end else begin
               bst_ra = d_ff - DW'(1);
            end
         end
         S_F1: begin
            bst_we = 1'b1; bst_wa = d_ff; bst_wd = bst_rd;
         end
         S_M0: ord_ra = idx_ff[VW-1:0];
         S_M1: begin
            head_ra = ord_rd; deg_ra = ord_rd;
         end
         S_E0: begin
            tgt_ra = e_ff[AW-1:0]; nxt_ra = e_ff[AW-1:0];
         end
         S_E1: deg_ra = tgt_rd;
         S_E2: begin
            pos_ra = u_ff; bst_ra = deg_rd;
         end
         S_E3: ord_ra = bst_rd[VW-1:0];
         S_E4: begin
            bst_we = 1'b1; bst_wa = du_ff; bst_wd = pw_ff + BW'(1);
            deg_we = 1'b1; deg_wa = u_ff; deg_wd = du_ff - DW'(1);
            if (u_ff != ord_rd) begin
               pos_we = 1'b1; pos_wa = u_ff; pos_wd = pw_ff[VW-1:0];
               ord_we = 1'b1; ord_wa = pu_ff; ord_wd = ord_rd;
            end
         end
         S_E5: begin
            pos_we = 1'b1; pos_wa = w_ff; pos_wd = pu_ff;
            ord_we = 1'b1; ord_wa = pw_ff[VW-1:0]; ord_wd = u_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR;
         idx_ff <= '0;
         clr_resp_ff <= 1'b0;
         vcount_ff <= kcd_pkg::VERTEX_COUNT_RESET;
         cnt_ff <= '0;
         decomp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!csr_we && st_ff == S_PUT && (!rsp_valid_ff || rsp_bus.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            vcount_ff <= csr_wdata;
            cnt_ff <= '0;
            decomp_ff <= 1'b0;
            idx_ff <= '0;
            clr_resp_ff <= 1'b0;
            st_ff <= S_CLR;
         end else begin
            unique case (st_ff)
               S_CLR: begin
                  idx_ff <= idx_ff + BW'(1);
                  if (idx_ff[VW-1:0] == VW'(MAX_VERTICES - 1)) begin
                     pst_ff <= kcd_pkg::STAT_OK;
                     pcore_ff <= '0;
                     st_ff <= clr_resp_ff ? S_PUT : S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_bus.valid) begin
                     pst_ff <= kcd_pkg::STAT_OK;
                     pcore_ff <= '0;
                     a_ff <= a_ext[VW-1:0];
                     b_ff <= b_ext[VW-1:0];
                     q_ff <= q_ext[VW-1:0];
                     st_ff <= S_PUT;
                     case (req_bus.req_type)
                        kcd_pkg::REQ_ADD_EDGE: begin
                           if (decomp_ff) begin
                              pst_ff <= kcd_pkg::STAT_PHASE;
                           end else if (a_ext >= live || b_ext >= live) begin
                              pst_ff <= kcd_pkg::STAT_RANGE;
                           end else begin
                              st_ff <= S_A0;
                           end
                        end
                        kcd_pkg::REQ_RUN: begin
                           if (decomp_ff) begin
                              pst_ff <= kcd_pkg::STAT_PHASE;
                           end else begin
                              idx_ff <= '0;
                              top_ff <= '0;
                              st_ff <= S_T0;
                           end
                        end
                        kcd_pkg::REQ_QUERY: begin
                           if (!decomp_ff) begin
                              pst_ff <= kcd_pkg::STAT_PHASE;
                           end else if (q_ext >= live) begin
                              pst_ff <= kcd_pkg::STAT_RANGE;
                           end else begin
                              st_ff <= S_Q0;
                           end
                        end
                        default: begin
                           cnt_ff <= '0;
                           decomp_ff <= 1'b0;
                           idx_ff <= '0;
                           clr_resp_ff <= 1'b1;
                           st_ff <= S_CLR;
                        end
                     endcase
                  end
               end
               S_PUT: begin
                  if (!rsp_valid_ff || rsp_bus.ready) begin
                     rsp_status_ff <= pst_ff;
                     rsp_core_ff <= pcore_ff;
                     st_ff <= S_IDLE;
                  end
               end
               S_A0: st_ff <= S_A1;
               S_A1: begin
                  da_ff <= deg_rd;
                  ha_ff <= head_rd;
                  st_ff <= S_A2;
               end
               S_A2: begin
                  if (add_fail) begin
                     pst_ff <= kcd_pkg::STAT_FULL;
                     st_ff <= S_PUT;
                  end else begin
                     db_ff <= deg_rd;
                     hb_ff <= (a_ff == b_ff) ? cnt_ff : head_rd;
                     st_ff <= S_A3;
                  end
               end
               S_A3: begin
                  cnt_ff <= PW'(cnt_plus2);
                  st_ff <= S_PUT;
               end
               S_Q0: st_ff <= S_Q1;
               S_Q1: begin
                  pcore_ff <= 10'(deg_rd);
                  st_ff <= S_PUT;
               end
               S_T0: begin
                  if (NW'(idx_ff) == live) begin
                     d_ff <= '0;
                     st_ff <= S_Z;
                  end else begin
                     st_ff <= S_T1;
                  end
               end
               S_T1: begin
                  if (deg_rd > top_ff) begin
                     top_ff <= deg_rd;
                  end
                  idx_ff <= idx_ff + BW'(1);
                  st_ff <= S_T0;
               end
               S_Z: begin
                  if (d_ff == top_ff) begin
                     idx_ff <= '0;
                     st_ff <= S_H0;
                  end else begin
                     d_ff <= d_ff + DW'(1);
                  end
               end
               S_H0: begin
                  if (NW'(idx_ff) == live) begin
                     d_ff <= '0;
                     sum_ff <= '0;
                     st_ff <= S_P0;
                  end else begin
                     st_ff <= S_H1;
                  end
               end
               S_H1: begin
                  du_ff <= deg_rd;
                  st_ff <= S_H2;
               end
               S_H2: begin
                  idx_ff <= idx_ff + BW'(1);
                  st_ff <= S_H0;
               end
               S_P0: st_ff <= S_P1;
               S_P1: begin
                  sum_ff <= sum_ff + bst_rd;
                  if (d_ff == top_ff) begin
                     idx_ff <= '0;
                     st_ff <= S_L0;
                  end else begin
                     d_ff <= d_ff + DW'(1);
                     st_ff <= S_P0;
                  end
               end
               S_L0: begin
                  if (NW'(idx_ff) == live) begin
                     d_ff <= top_ff;
                     st_ff <= S_F0;
                  end else begin
                     st_ff <= S_L1;
                  end
               end
               S_L1: begin
                  du_ff <= deg_rd;
                  st_ff <= S_L2;
               end
               S_L2: begin
                  idx_ff <= idx_ff + BW'(1);
                  st_ff <= S_L0;
               end
               S_F0: begin
                  if (d_ff == '0) begin
                     idx_ff <= '0;
                     st_ff <= S_M0;
                  end else begin
                     st_ff <= S_F1;
                  end
               end
               S_F1: begin
                  d_ff <= d_ff - DW'(1);
                  st_ff <= S_F0;
               end
               S_M0: begin
                  if (NW'(idx_ff) == live) begin
                     decomp_ff <= 1'b1;
                     st_ff <= S_PUT;
                  end else begin
                     st_ff <= S_M1;
                  end
               end
               S_M1: begin
                  cur_ff <= ord_rd;
                  st_ff <= S_M2;
               end
               S_M2: begin
                  e_ff <= head_rd;
                  dcur_ff <= deg_rd;
                  st_ff <= S_E0;
               end
               S_E0: begin
                  if (e_ff >= EMPTY) begin
                     idx_ff <= idx_ff + BW'(1);
                     st_ff <= S_M0;
                  end else begin
                     st_ff <= S_E1;
                  end
               end
               S_E1: begin
                  u_ff <= tgt_rd;
                  ne_ff <= nxt_rd;
                  st_ff <= S_E2;
               end
               S_E2: begin
                  du_ff <= deg_rd;
                  if (deg_rd > dcur_ff) begin
                     st_ff <= S_E3;
                  end else begin
                     e_ff <= ne_ff;
                     st_ff <= S_E0;
                  end
               end
               S_E3: begin
                  pu_ff <= pos_rd;
                  pw_ff <= bst_rd;
                  st_ff <= S_E4;
               end
               S_E4: begin
                  w_ff <= ord_rd;
                  if (u_ff != ord_rd) begin
                     st_ff <= S_E5;
                  end else begin
                     e_ff <= ne_ff;
                     st_ff <= S_E0;
                  end
               end
               S_E5: begin
                  e_ff <= ne_ff;
                  st_ff <= S_E0;
               end
               default: st_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_bus.ready       = (st_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.core_number = rsp_core_ff;
endmodule
